// ----- sv/ddpr_pkg.sv -----
// Shared types, constants and helpers of the differential drive position regulator.
package ddpr_pkg;

  // Fixed point and encoder format
  localparam int COUNT_WIDTH = 16;
  localparam int FRAC_BITS   = 16;

  // Port field widths
  localparam int ORDER_W    = 2;
  localparam int AMOUNT_W   = 8;
  localparam int CNT_IN_W   = 16;
  localparam int DUTY_W     = 15;
  localparam int PERIOD_W   = 14;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 17;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q16 register to Q(FRAC_BITS) conversion
  localparam int UPSHIFT   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWNSHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int FQ_W      = LIMIT_W + UPSHIFT;

  // Datapath widths
  localparam int SUM_W     = COUNT_WIDTH + 1;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int RD_W      = 33;
  localparam int RG_W      = 41;
  localparam int DRV_W     = FQ_W + 2;
  localparam int ERR_W     = 32;
  localparam int GAIN_FRAC = 16;

  // Q0.32 scale constants, products rounded by K_SH
  localparam int K_SH = 32 - FRAC_BITS;
  localparam logic [MUL_B_W-1:0] K_DIST = 32'd384177;
  localparam logic [MUL_B_W-1:0] K_HEAD = 32'd5733982;
  localparam logic [MUL_B_W-1:0] K_DEG  = 32'd74961321;

  // Centimetres to metres: floor((amount * 2^FRAC_BITS + 50) / 100) by reciprocal
  localparam int CM_BIAS  = 50;
  localparam int X_W      = AMOUNT_W + FRAC_BITS;
  localparam int RECIP_SH = X_W + 7;
  localparam logic [MUL_A_W-1:0] RECIP_M =
    MUL_A_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);

  // Request codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [ORDER_W-1:0] {
    MOVE_FWD, MOVE_BACK, MOVE_RIGHT, MOVE_LEFT
  } move_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN, REG_TRANSL_LIMIT, REG_ROT_LIMIT, REG_PWM_PERIOD,
    REG_STRAIGHT_TOL, REG_RIGHT_TOL, REG_LEFT_TOL
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [LIMIT_W-1:0]  transl_limit;
    logic [LIMIT_W-1:0]  rot_limit;
    logic [PERIOD_W-1:0] pwm_period;
    logic [TOL_W-1:0]    straight_tol;
    logic [TOL_W-1:0]    right_tol;
    logic [TOL_W-1:0]    left_tol;
  } cfg_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic              left_reverse;
    logic [DUTY_W-1:0] right_duty;
    logic              right_reverse;
    logic              move_done;
    logic              moving;
  } result_t;

  // Q16 to Q(FRAC_BITS), truncating when the format is narrower
  function automatic logic [FQ_W-1:0] from_q16(input logic [LIMIT_W-1:0] v);
    logic [FQ_W-1:0] w;
    w = FQ_W'(v) << UPSHIFT;
    return w >> DOWNSHIFT;
  endfunction

endpackage

// ----- sv/ddpr_req_if.sv -----
// Request channel: start and tick requests with valid/ready handshake.
interface ddpr_req_if import ddpr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ORDER_W-1:0]         order;
  logic [AMOUNT_W-1:0]        amount;
  logic signed [CNT_IN_W-1:0] left_count;
  logic signed [CNT_IN_W-1:0] right_count;

  modport source (output valid, cmd, order, amount, left_count, right_count,
                  input ready);
  modport sink   (input valid, cmd, order, amount, left_count, right_count,
                  output ready);
endinterface

// ----- sv/ddpr_rsp_if.sv -----
// Result channel: PWM duties, direction bits and move status.
interface ddpr_rsp_if import ddpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_duty;
  logic              left_reverse;
  logic [DUTY_W-1:0] right_duty;
  logic              right_reverse;
  logic              move_done;
  logic              moving;

  modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                  move_done, moving, input ready);
  modport sink   (input valid, left_duty, left_reverse, right_duty, right_reverse,
                  move_done, moving, output ready);
endinterface

// ----- sv/ddpr_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface ddpr_cfg_if import ddpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ddpr_cfg_regs.sv -----
// Configuration register file with reset defaults.
module ddpr_cfg_regs import ddpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ddpr_cfg_if.sink   cfg,
  output cfg_t       cfg_q
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.gain         <= GAIN_W'(241828);
      cfg_q.transl_limit <= LIMIT_W'(19661);
      cfg_q.rot_limit    <= LIMIT_W'(16384);
      cfg_q.pwm_period   <= PERIOD_W'(2666);
      cfg_q.straight_tol <= TOL_W'(983);
      cfg_q.right_tol    <= TOL_W'(655);
      cfg_q.left_tol     <= TOL_W'(3604);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_GAIN:         cfg_q.gain         <= cfg.data[GAIN_W-1:0];
        REG_TRANSL_LIMIT: cfg_q.transl_limit <= cfg.data[LIMIT_W-1:0];
        REG_ROT_LIMIT:    cfg_q.rot_limit    <= cfg.data[LIMIT_W-1:0];
        REG_PWM_PERIOD:   cfg_q.pwm_period   <= cfg.data[PERIOD_W-1:0];
        REG_STRAIGHT_TOL: cfg_q.straight_tol <= cfg.data[TOL_W-1:0];
        REG_RIGHT_TOL:    cfg_q.right_tol    <= cfg.data[TOL_W-1:0];
        REG_LEFT_TOL:     cfg_q.left_tol     <= cfg.data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/ddpr_mul.sv -----
// Shared unsigned multiplier with registered product.
module ddpr_mul import ddpr_pkg::*; (
  input  logic              clk,
  input  mul_op_t           op,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a) * PROD_W'(op.b);
  end

endmodule

// ----- sv/ddpr_ctrl.sv -----
// Sequencer and datapath registers: move set-up, end test, errors, clamp, mix, duties.
module ddpr_ctrl import ddpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ddpr_req_if.sink          req,
  input  cfg_t              cfg_q,
  output mul_op_t           mul_op,
  input  logic [PROD_W-1:0] prod,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           res
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_START_D, S_START_A, S_START_T,
    S_DIST, S_HEAD, S_ERR_D, S_ERR_H, S_GAIN_T, S_GAIN_R,
    S_CLAMP_T, S_CLAMP_R, S_MIX, S_DUTY_L, S_DUTY_R, S_DUTY_END, S_RESULT
  } state_t;

  state_t state;

  // control
  logic  active;
  logic  first_tick;
  move_t move_kind;

  // payload
  logic [AMOUNT_W-1:0]     amt;
  logic signed [ERR_W-1:0] target_distance;
  logic signed [ERR_W-1:0] target_heading;
  logic signed [ERR_W-1:0] last_distance_error;
  logic signed [ERR_W-1:0] last_heading_error;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] diff;
  logic [RD_W-1:0]         rd;
  logic [RD_W-1:0]         rh;
  logic [RG_W-1:0]         rt;
  logic [RG_W-1:0]         rr;
  logic signed [FQ_W:0]    tl;
  logic signed [FQ_W:0]    rl;
  logic signed [DRV_W-1:0] dl;
  logic signed [DRV_W-1:0] dr;

  logic [PROD_W-1:0] rnd_k;
  logic [PROD_W-1:0] rnd_g;
  logic [PROD_W-1:0] trunc_f;
  logic [PROD_W-1:0] trunc_r;
  logic [DUTY_W-1:0] top;
  logic [DUTY_W-1:0] duty;
  logic              go;
  logic signed [SUM_W-1:0] cnt_l;
  logic signed [SUM_W-1:0] cnt_r;

  function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic logic [ERR_W-1:0] mag_err(input logic signed [ERR_W-1:0] v);
    return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
  endfunction

  function automatic logic [DRV_W-1:0] mag_drv(input logic signed [DRV_W-1:0] v);
    return v[DRV_W-1] ? DRV_W'(-v) : DRV_W'(v);
  endfunction

  // target minus signed rounded magnitude, saturated to 32 bits
  function automatic logic signed [ERR_W-1:0] err_sat(
    input logic signed [ERR_W-1:0] target,
    input logic                    neg,
    input logic [RD_W-1:0]         m
  );
    logic signed [RD_W:0]   sv;
    logic signed [RD_W+1:0] e;
    sv = $signed({1'b0, m});
    if (neg) begin
      sv = -sv;
    end
    e = (RD_W+2)'(target) - (RD_W+2)'(sv);
    if (e > (RD_W+2)'(33'sh0_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (e < -(RD_W+2)'(34'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return e[ERR_W-1:0];
  endfunction

  // sign times min(magnitude, limit)
  function automatic logic signed [FQ_W:0] clamp_drv(
    input logic            neg,
    input logic [RG_W-1:0] m,
    input logic [FQ_W-1:0] lim
  );
    logic [FQ_W-1:0]      mn;
    logic signed [FQ_W:0] v;
    mn = (m > RG_W'(lim)) ? lim : m[FQ_W-1:0];
    v  = $signed({1'b0, mn});
    return neg ? -v : v;
  endfunction

  assign cnt_l = SUM_W'($signed(req.left_count[COUNT_WIDTH-1:0]));
  assign cnt_r = SUM_W'($signed(req.right_count[COUNT_WIDTH-1:0]));

  assign rnd_k   = (prod + (PROD_W'(1) << (K_SH - 1))) >> K_SH;
  assign rnd_g   = (prod + (PROD_W'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
  assign trunc_f = prod >> FRAC_BITS;
  assign trunc_r = prod >> RECIP_SH;
  assign top     = DUTY_W'(cfg_q.pwm_period) + DUTY_W'(1);
  assign duty    = (trunc_f > PROD_W'(top)) ? top : trunc_f[DUTY_W-1:0];

  // end-of-move test on the error left by the previous tick
  always_comb begin
    go = 1'b1;
    if (!first_tick) begin
      case (move_kind)
        MOVE_FWD:   go = last_distance_error >
                         $signed({1'b0, from_q16({1'b0, cfg_q.straight_tol})});
        MOVE_BACK:  go = last_distance_error <
                         -$signed({1'b0, from_q16({1'b0, cfg_q.straight_tol})});
        MOVE_RIGHT: go = last_heading_error >
                         $signed({1'b0, from_q16({1'b0, cfg_q.right_tol})});
        MOVE_LEFT:  go = last_heading_error <
                         -$signed({1'b0, from_q16({1'b0, cfg_q.left_tol})});
        default:    go = 1'b1;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state)
      S_START_D: begin
        mul_op.a = RECIP_M;
        mul_op.b = MUL_B_W'({amt, FRAC_BITS'(0)}) + MUL_B_W'(CM_BIAS);
      end
      S_START_A: begin
        mul_op.a = MUL_A_W'(amt);
        mul_op.b = K_DEG;
      end
      S_DIST: begin
        mul_op.a = MUL_A_W'(mag_sum(sum));
        mul_op.b = K_DIST;
      end
      S_HEAD: begin
        mul_op.a = MUL_A_W'(mag_sum(diff));
        mul_op.b = K_HEAD;
      end
      S_GAIN_T: begin
        mul_op.a = MUL_A_W'(mag_err(last_distance_error));
        mul_op.b = MUL_B_W'(cfg_q.gain);
      end
      S_GAIN_R: begin
        mul_op.a = MUL_A_W'(mag_err(last_heading_error));
        mul_op.b = MUL_B_W'(cfg_q.gain);
      end
      S_DUTY_L: begin
        mul_op.a = MUL_A_W'(mag_drv(dl));
        mul_op.b = MUL_B_W'(top);
      end
      S_DUTY_R: begin
        mul_op.a = MUL_A_W'(mag_drv(dr));
        mul_op.b = MUL_B_W'(top);
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= 1'b0;
      first_tick <= 1'b1;
      move_kind  <= MOVE_FWD;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            // drive fields default to zero drive
            res.left_duty     <= '0;
            res.left_reverse  <= 1'b1;
            res.right_duty    <= '0;
            res.right_reverse <= 1'b1;
            res.move_done     <= 1'b0;
            res.moving        <= active;
            if (req.cmd == CMD_START) begin
              move_kind  <= move_t'(req.order);
              amt        <= req.amount;
              active     <= 1'b1;
              first_tick <= 1'b1;
              state      <= S_START_D;
            end else if (active) begin
              sum   <= cnt_l + cnt_r;
              diff  <= cnt_l - cnt_r;
              state <= S_CHECK;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_START_D: state <= S_START_A;
        S_START_A: begin
          rd    <= trunc_r[RD_W-1:0];
          state <= S_START_T;
        end
        S_START_T: begin
          case (move_kind)
            MOVE_FWD: begin
              target_distance <= rd[ERR_W-1:0];
              target_heading  <= '0;
            end
            MOVE_BACK: begin
              target_distance <= -$signed(rd[ERR_W-1:0]);
              target_heading  <= '0;
            end
            MOVE_RIGHT: begin
              target_distance <= '0;
              target_heading  <= rnd_k[ERR_W-1:0];
            end
            MOVE_LEFT: begin
              target_distance <= '0;
              target_heading  <= -$signed(rnd_k[ERR_W-1:0]);
            end
            default: begin
              target_distance <= '0;
              target_heading  <= '0;
            end
          endcase
          res.moving <= 1'b1;
          state      <= S_RESULT;
        end
        S_CHECK: begin
          if (!go) begin
            active        <= 1'b0;
            first_tick    <= 1'b1;
            res.move_done <= 1'b1;
            res.moving    <= 1'b0;
            state         <= S_RESULT;
          end else begin
            state <= S_DIST;
          end
        end
        S_DIST: state <= S_HEAD;
        S_HEAD: begin
          rd    <= rnd_k[RD_W-1:0];
          state <= S_ERR_D;
        end
        S_ERR_D: begin
          rh                  <= rnd_k[RD_W-1:0];
          last_distance_error <= err_sat(target_distance, sum[SUM_W-1], rd);
          state               <= S_ERR_H;
        end
        S_ERR_H: begin
          last_heading_error <= err_sat(target_heading, diff[SUM_W-1], rh);
          first_tick         <= 1'b0;
          state              <= S_GAIN_T;
        end
        S_GAIN_T: state <= S_GAIN_R;
        S_GAIN_R: begin
          rt    <= rnd_g[RG_W-1:0];
          state <= S_CLAMP_T;
        end
        S_CLAMP_T: begin
          rr    <= rnd_g[RG_W-1:0];
          tl    <= clamp_drv(last_distance_error[ERR_W-1], rt,
                             from_q16(cfg_q.transl_limit));
          state <= S_CLAMP_R;
        end
        S_CLAMP_R: begin
          rl    <= clamp_drv(last_heading_error[ERR_W-1], rr,
                             from_q16(cfg_q.rot_limit));
          state <= S_MIX;
        end
        S_MIX: begin
          dl    <= DRV_W'(tl) + DRV_W'(rl);
          dr    <= DRV_W'(tl) - DRV_W'(rl);
          state <= S_DUTY_L;
        end
        S_DUTY_L: state <= S_DUTY_R;
        S_DUTY_R: begin
          res.left_duty    <= duty;
          res.left_reverse <= dl[DRV_W-1] || (dl == '0);
          state            <= S_DUTY_END;
        end
        S_DUTY_END: begin
          res.right_duty    <= duty;
          res.right_reverse <= dr[DRV_W-1] || (dr == '0);
          res.moving        <= 1'b1;
          state             <= S_RESULT;
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/diff_drive_position_regulator.sv -----
// Top level of the differential drive proportional position regulator.
//
// A start request loads a move (forward or backward by amount centimetres, right or
// left turn by amount degrees) and answers with zero drive and moving set. Each tick
// request brings the two encoder counts since the move began; the regulator tests the
// error left by the previous tick against the move's tolerance, and either finishes
// the move (zero drive, move_done) or works out mean distance and heading, scales
// both errors by the gain, clamps them and mixes them into two PWM duties with
// direction bits. A tick while no move runs answers with zero drive at once. All
// products go through one shared 33 x 32 multiplier with a registered product,
// stepped by a small sequencer, so one request is in work at a time. The request
// side is ready again once the result has moved into the output register, so the
// next request may be accepted while that result still waits to be taken.
// Configuration writes are taken on any cycle and should only be issued while
// the block is idle.
module diff_drive_position_regulator import ddpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ddpr_req_if.sink   req,
  ddpr_rsp_if.source rsp,
  ddpr_cfg_if.sink   cfg
);

  cfg_t              cfg_q;
  mul_op_t           mul_op;
  logic [PROD_W-1:0] prod;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              out_valid;
  result_t           out_res;

  ddpr_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  ddpr_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  ddpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_q     (cfg_q),
    .mul_op    (mul_op),
    .prod      (prod),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: take a finished result when empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset; only loaded alongside out_valid
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.left_duty     = out_res.left_duty;
  assign rsp.left_reverse  = out_res.left_reverse;
  assign rsp.right_duty    = out_res.right_duty;
  assign rsp.right_reverse = out_res.right_reverse;
  assign rsp.move_done     = out_res.move_done;
  assign rsp.moving        = out_res.moving;

  // A request in work closes the request side on the next cycle.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another was still in work");

  // A result not yet taken by the output register is held unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result changed before hand-over");

  // A finished move always reports zero drive and no motion.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.move_done |->
      !rsp.moving && (rsp.left_duty == '0) && (rsp.right_duty == '0) &&
      rsp.left_reverse && rsp.right_reverse)
    else $error("finishing result carries drive or motion");

  // Duties never pass full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |->
      (rsp.left_duty <= DUTY_W'(cfg_q.pwm_period) + DUTY_W'(1)) &&
      (rsp.right_duty <= DUTY_W'(cfg_q.pwm_period) + DUTY_W'(1)))
    else $error("duty beyond period plus one");

endmodule
